[hdl/udprx_pkg.sv]
`default_nettype none

package udprx_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam logic [15:0] MIN_UDP_LEN  = 16'd8;
   localparam logic [15:0] UDP_PROTOCOL = 16'd17;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_OPEN  = 2'd1,
      ACT_CLOSE = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      VERDICT_DELIVERED   = 3'd0,
      VERDICT_TOO_SHORT   = 3'd1,
      VERDICT_CSUM_BAD    = 3'd2,
      VERDICT_UNREACHABLE = 3'd3,
      VERDICT_OPENED      = 3'd4,
      VERDICT_FULL        = 3'd5
   } verdict_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD,
      ST_SRC_HI,
      ST_SRC_LO,
      ST_LOC_HI,
      ST_LOC_LO,
      ST_PROTO,
      ST_LEN,
      ST_VERDICT,
      ST_OPEN,
      ST_CLOSE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      ADD_PAD,
      ADD_SRC_HI,
      ADD_SRC_LO,
      ADD_LOC_HI,
      ADD_LOC_LO,
      ADD_PROTO,
      ADD_LEN
   } add_sel_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] sender_ip;
      logic [15:0] port_number;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [3:0]  slot;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [15:0] payload_length;
   } rsp_type;

   // controller -> datapath / table
   typedef struct packed {
      logic        take_byte;
      logic        take_port;
      logic        add_en;
      add_sel_type add_sel;
      logic        load_verdict;
      logic        load_open;
      logic        tbl_open;
      logic        tbl_close;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // table -> datapath
   typedef struct packed {
      logic       lookup_hit;
      logic [3:0] lookup_slot;
      logic       open_ok;
      logic [3:0] open_slot;
   } tbl_status_type;

   // ones'-complement add with end-around carry
   function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? (s[15:0] + 16'd1) : s[15:0];
   endfunction

endpackage

`default_nettype wire

[hdl/udprx_table.sv]
`default_nettype none

module udprx_table
   import udprx_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ctrl_cmd_type   cmd,
   input  wire logic [15:0]    cmd_port,
   input  wire logic [15:0]    lookup_port,
   output tbl_status_type      status
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [15:0]              port_ff [TABLE_ENTRIES];
   logic [15:0]              port_in [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] match_vec, hit_vec;
   logic                     match_any, free_any, hit_any;
   logic [IDX_W-1:0]         match_idx, free_idx, hit_idx, open_idx;

   // parallel compare against every entry, lowest index wins
   always_comb begin
      match_any = 1'b0;
      free_any  = 1'b0;
      hit_any   = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      hit_idx   = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_vec[i] = (port_ff[i] == cmd_port);
         hit_vec[i]   = valid_ff[i] && (port_ff[i] == lookup_port);
      end
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_any = 1'b1;
            match_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
      open_idx = match_any ? match_idx : free_idx;
   end

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         port_in[i] = port_ff[i];
      end
      if (cmd.tbl_open && (match_any || free_any)) begin
         valid_in[open_idx] = 1'b1;
         port_in[open_idx]  = cmd_port;
      end
      if (cmd.tbl_close) begin
         valid_in = valid_ff & ~match_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            port_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            port_ff[i] <= port_in[i];
         end
      end
   end

   assign status.lookup_hit  = hit_any;
   assign status.lookup_slot = 4'(hit_idx);
   assign status.open_ok     = match_any || free_any;
   assign status.open_slot   = 4'(open_idx);

endmodule

`default_nettype wire

[hdl/udprx_ctrl.sv]
`default_nettype none

module udprx_ctrl
   import udprx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_action,
   input  wire logic          req_last,
   input  wire dp_status_type dp_status,
   output logic               req_stall,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic           take;

   assign take = (state_ff == ST_IDLE) && req_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_BYTE) begin
                  if (req_last) state_in = ST_PAD;
               end else if (req_action == ACT_OPEN) begin
                  state_in = ST_OPEN;
               end else if (req_action == ACT_CLOSE) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_PAD:     state_in = ST_SRC_HI;
         ST_SRC_HI:  state_in = ST_SRC_LO;
         ST_SRC_LO:  state_in = ST_LOC_HI;
         ST_LOC_HI:  state_in = ST_LOC_LO;
         ST_LOC_LO:  state_in = ST_PROTO;
         ST_PROTO:   state_in = ST_LEN;
         ST_LEN:     state_in = ST_VERDICT;
         ST_VERDICT: if (dp_status.out_free) state_in = ST_IDLE;
         ST_OPEN:    if (dp_status.out_free) state_in = ST_IDLE;
         ST_CLOSE:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      cmd              = '0;
      cmd.add_sel      = ADD_PAD;
      cmd.take_byte    = take && (req_action == ACT_BYTE);
      cmd.take_port    = take && ((req_action == ACT_OPEN) || (req_action == ACT_CLOSE));
      case (state_ff)
         ST_PAD:    begin cmd.add_en = 1'b1; cmd.add_sel = ADD_PAD;    end
         ST_SRC_HI: begin cmd.add_en = 1'b1; cmd.add_sel = ADD_SRC_HI; end
         ST_SRC_LO: begin cmd.add_en = 1'b1; cmd.add_sel = ADD_SRC_LO; end
         ST_LOC_HI: begin cmd.add_en = 1'b1; cmd.add_sel = ADD_LOC_HI; end
         ST_LOC_LO: begin cmd.add_en = 1'b1; cmd.add_sel = ADD_LOC_LO; end
         ST_PROTO:  begin cmd.add_en = 1'b1; cmd.add_sel = ADD_PROTO;  end
         ST_LEN:    begin cmd.add_en = 1'b1; cmd.add_sel = ADD_LEN;    end
         ST_VERDICT: cmd.load_verdict = dp_status.out_free;
         ST_OPEN: begin
            cmd.load_open = dp_status.out_free;
            cmd.tbl_open  = dp_status.out_free;
         end
         ST_CLOSE: cmd.tbl_close = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/udprx_dp.sv]
`default_nettype none

module udprx_dp
   import udprx_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire req_type        req_data,
   input  wire logic           csr_wr_en,
   input  wire logic [31:0]    csr_wr_data,
   input  wire ctrl_cmd_type   cmd,
   input  wire tbl_status_type tbl_status,
   input  wire logic           rsp_stall,
   output dp_status_type       status,
   output logic [15:0]         port_out,
   output logic [15:0]         dst_port,
   output logic                rsp_valid,
   output rsp_type             rsp_data
);

   logic [31:0] local_ip_ff, local_ip_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  held_ff, held_in;
   logic [63:0] header_ff, header_in;
   logic [31:0] sender_ff, sender_in;
   logic [15:0] port_ff, port_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0] add_word;
   logic [15:0] hdr_src_port, len_field, rx_sum, computed;
   logic        short_dg;
   logic        out_free;

   assign hdr_src_port = header_ff[63:48];
   assign dst_port     = header_ff[47:32];
   assign len_field    = header_ff[31:16];
   assign rx_sum       = header_ff[15:0];

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign status.out_free = out_free;
   assign port_out        = port_ff;

   always_comb begin
      case (cmd.add_sel)
         ADD_PAD:    add_word = count_ff[0] ? {held_ff, 8'h00} : 16'h0000;
         ADD_SRC_HI: add_word = sender_ff[31:16];
         ADD_SRC_LO: add_word = sender_ff[15:0];
         ADD_LOC_HI: add_word = local_ip_ff[31:16];
         ADD_LOC_LO: add_word = local_ip_ff[15:0];
         ADD_PROTO:  add_word = UDP_PROTOCOL;
         ADD_LEN:    add_word = len_field;
         default:    add_word = 16'h0000;
      endcase
   end

   always_comb begin
      computed = ~sum_ff;
      if (computed == 16'h0000) computed = 16'hFFFF;
      short_dg = (len_field < MIN_UDP_LEN) || (count_ff < MIN_UDP_LEN);
   end

   always_comb begin
      local_ip_in  = csr_wr_en ? csr_wr_data : local_ip_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      held_in      = held_ff;
      header_in    = header_ff;
      sender_in    = sender_ff;
      port_in      = cmd.take_port ? req_data.port_number : port_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (cmd.take_byte) begin
         if (count_ff == 16'd0) sender_in = req_data.sender_ip;
         if (count_ff < MIN_UDP_LEN) begin
            header_in[{~count_ff[2:0], 3'b000} +: 8] = req_data.data_byte;
         end
         if (!count_ff[0]) begin
            held_in = req_data.data_byte;
         end else if (count_ff != 16'd7) begin
            // bytes 6 and 7 carry the checksum field, counted as zero
            sum_in = add_ones(sum_ff, {held_ff, req_data.data_byte});
         end
         // saturate while keeping parity right
         count_in = (count_ff == 16'hFFFF) ? 16'hFFFE : count_ff + 16'd1;
      end

      if (cmd.add_en) begin
         sum_in = add_ones(sum_ff, add_word);
      end

      if (cmd.load_verdict) begin
         rsp_valid_in            = 1'b1;
         rsp_in.source_port      = hdr_src_port;
         rsp_in.destination_port = dst_port;
         rsp_in.slot             = 4'd0;
         rsp_in.payload_length   = 16'd0;
         if (short_dg) begin
            rsp_in.verdict = VERDICT_TOO_SHORT;
         end else begin
            rsp_in.payload_length = len_field - MIN_UDP_LEN;
            if ((rx_sum != 16'h0000) && (computed != rx_sum)) begin
               rsp_in.verdict = VERDICT_CSUM_BAD;
            end else if (!tbl_status.lookup_hit) begin
               rsp_in.verdict = VERDICT_UNREACHABLE;
            end else begin
               rsp_in.verdict = VERDICT_DELIVERED;
               rsp_in.slot    = tbl_status.lookup_slot;
            end
         end
         sum_in    = '0;
         count_in  = '0;
         held_in   = '0;
         header_in = '0;
      end

      if (cmd.load_open) begin
         rsp_valid_in            = 1'b1;
         rsp_in.source_port      = 16'd0;
         rsp_in.destination_port = 16'd0;
         rsp_in.payload_length   = 16'd0;
         if (tbl_status.open_ok) begin
            rsp_in.verdict = VERDICT_OPENED;
            rsp_in.slot    = tbl_status.open_slot;
         end else begin
            rsp_in.verdict = VERDICT_FULL;
            rsp_in.slot    = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         header_ff    <= '0;
         sender_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         local_ip_ff  <= local_ip_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         header_ff    <= header_in;
         sender_ff    <= sender_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff <= port_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[hdl/udp_receive_check_and_port_demux.sv]
// Datagram bytes that are not last: one beat per cycle, no result.
// Last byte: padding and pseudo header folded one word per cycle through a
// ones'-complement adder, verdict loaded once output is free; next beat taken after.
// Open port: entry and result written once output is free; close gives no result.
// Synchronous active-high reset clears the port table, checksum state and local_ip.
`default_nettype none

module udp_receive_check_and_port_demux
   import udprx_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   ctrl_cmd_type   cmd;
   dp_status_type  dp_status;
   tbl_status_type tbl_status;
   logic [15:0]    cmd_port;
   logic [15:0]    dst_port;

   udprx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_last   (req_data.last_byte),
      .dp_status  (dp_status),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   udprx_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .tbl_status  (tbl_status),
      .rsp_stall   (rsp_stall),
      .status      (dp_status),
      .port_out    (cmd_port),
      .dst_port    (dst_port),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   udprx_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cmd_port    (cmd_port),
      .lookup_port (dst_port),
      .status      (tbl_status)
   );

endmodule

`default_nettype wire
